// File: rtl/core/lsppm_pkg.sv
// Shared types and constants for the log-curve gas sensor ppm converter and its testbench.
// No dependencies; imported by log_sensor_ppm_with_moving_average.
package lsppm_pkg;

	localparam int MV_W    = 12;
	localparam int SLOPE_W = 16;
	localparam int PPM_W   = 14;
	localparam int PROD_W  = MV_W + SLOPE_W;
	localparam int EXP_W   = PROD_W - 6 + 1;
	localparam int ACC_W   = 32;
	localparam int POW_W   = 30;
	localparam int FRAC_W  = 28;
	localparam int STEP_N  = 10;
	localparam int SCL_W   = 10;
	localparam int MDATA_W = 32;

	localparam logic [EXP_W-1:0] EXP_BASE = EXP_W'(2664);
	localparam logic [EXP_W-1:0] EXP_SAT  = EXP_W'(4096);
	localparam logic [PPM_W-1:0] PPM_MIN  = PPM_W'(400);
	localparam logic [PPM_W-1:0] PPM_MAX  = PPM_W'(10000);
	localparam logic [ACC_W-1:0] Q28_ONE  = ACC_W'(32'h1000_0000);
	localparam logic [SCL_W-1:0] SCALE_HI = SCL_W'(1000);
	localparam logic [SCL_W-1:0] SCALE_LO = SCL_W'(100);
	localparam logic [SLOPE_W-1:0] SLOPE_RST = SLOPE_W'(102);

	typedef enum logic {
		REG_ZERO_POINT = 1'b0,
		REG_SLOPE      = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_POW,
		ST_SCALE,
		ST_SUM,
		ST_DIV,
		ST_OUT
	} state_t;

	// 10^(2^k/1024) in Q.28, rounded
	localparam logic [POW_W-1:0] POW10_Q28 [STEP_N] = '{
		30'd269039744, 30'd269645392, 30'd270860782, 30'd273308022, 30'd278269033,
		30'd288462842, 30'd309984429, 30'd357964434, 30'd477353244, 30'd848867446
	};

endpackage

// File: rtl/core/log_sensor_ppm_with_moving_average.sv
// Top level: sensor mV to ppm through a log-linear curve, plus a moving average.
// Depends on lsppm_pkg; holds the sample ring as an internal memory.
//
//  channel  dir  fields (lowest bit up)
//  s_*      in   sample_mv[SAMPLE_BITS]
//  m_*      out  instant_ppm[14], average_ppm[14], window_full[1]
//  cfg_*    in   0: zero_point_mv[12], 1: slope_q16[16]
//
// Steps per item below the zero point: accept, 12 bit-serial multiply steps, 10
// power-of-ten steps, scale, sum, TW divider steps, output load; when the exponent
// saturates, one power step and no scale; at or above the zero point, only accept,
// sum, divider steps and output load. TW = clog2(10000*WINDOW+1), 18 at WINDOW = 16.
// The restoring divider yields one quotient bit per cycle; a new sample is taken only when idle.
// Reset clears control and the ring pointer; ring contents stay undefined.
// A result waiting in the output register does not block the next transfer in;
// the output load step holds until that register drains.
module log_sensor_ppm_with_moving_average #(
	parameter int WINDOW      = 16,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,  // sample_mv
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lsppm_pkg::MDATA_W-1:0]     m_tdata,  // instant_ppm, average_ppm, window_full
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [lsppm_pkg::SLOPE_W-1:0]     cfg_data
);
	import lsppm_pkg::*;

	localparam int CMP_W  = (SAMPLE_BITS > MV_W) ? SAMPLE_BITS : MV_W;
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int TOT_W  = $clog2(10000 * WINDOW + 1);
	localparam int DC_W   = $clog2(TOT_W + 1);
	localparam int STEP_W = (DC_W > 4) ? DC_W : 4;

	state_t state_q, state_d;

	logic [MV_W-1:0]    zero_q;
	logic [SLOPE_W-1:0] slope_q;

	logic [STEP_W-1:0]  step_q;
	logic [MV_W-1:0]    d_q;
	logic [PROD_W-1:0]  prod_q;
	logic [ACC_W-1:0]   acc_q;
	logic [PPM_W-1:0]   inst_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               full_q;
	logic [TOT_W-1:0]   total_q;
	logic [TOT_W-1:0]   quo_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   div_q;
	logic [PPM_W-1:0]   rd_q;

	logic               m_valid_q;
	logic [PPM_W-1:0]   m_inst_q;
	logic [PPM_W-1:0]   m_avg_q;
	logic               m_full_q;

	logic [PPM_W-1:0]   ring_mem [WINDOW];

	logic               s_fire;
	logic               ring_we;
	logic               out_load;
	logic [CMP_W-1:0]   mv_ext;
	logic [CMP_W-1:0]   zero_ext;
	logic               at_zero;
	logic [EXP_W-1:0]   exp_v;
	logic               exp_sat;
	logic [61:0]        pw_prod;
	logic [41:0]        sc_prod;
	logic [PPM_W-1:0]   ppm_raw;
	logic [PPM_W-1:0]   ppm_clamp;
	logic [TOT_W-1:0]   total_nxt;
	logic [CNT_W-1:0]   slot_inc;
	logic               slot_last;
	logic [CNT_W:0]     rem_sh;
	logic               rem_ge;
	logic [CNT_W:0]     rem_sub;

	assign s_fire   = s_tvalid && s_tready;
	assign mv_ext   = CMP_W'(s_tdata[SAMPLE_BITS-1:0]);
	assign zero_ext = CMP_W'(zero_q);
	assign at_zero  = mv_ext >= zero_ext;

	assign exp_v   = EXP_BASE + EXP_W'(prod_q[PROD_W-1:6]);
	assign exp_sat = exp_v >= EXP_SAT;
	assign pw_prod = 62'(acc_q) * 62'(POW10_Q28[step_q[3:0]]);
	assign sc_prod = 42'(acc_q) * 42'(exp_v[10] ? SCALE_HI : SCALE_LO);
	assign ppm_raw = sc_prod[41:28];

	always_comb begin
		if (ppm_raw < PPM_MIN) begin
			ppm_clamp = PPM_MIN;
		end else if (ppm_raw > PPM_MAX) begin
			ppm_clamp = PPM_MAX;
		end else begin
			ppm_clamp = ppm_raw;
		end
	end

	assign total_nxt = total_q - (full_q ? TOT_W'(rd_q) : '0) + TOT_W'(inst_q);
	assign slot_inc  = CNT_W'(slot_q) + CNT_W'(1);
	assign slot_last = slot_inc >= CNT_W'(WINDOW);

	assign rem_sh  = {rem_q, quo_q[TOT_W-1]};
	assign rem_ge  = rem_sh >= {1'b0, div_q};
	assign rem_sub = rem_sh - {1'b0, div_q};

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q  <= '0;
			slope_q <= SLOPE_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ZERO_POINT: zero_q  <= cfg_data[MV_W-1:0];
				REG_SLOPE:      slope_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		ring_we  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = at_zero ? ST_SUM : ST_MUL;
				end
			end
			ST_MUL: begin
				if (step_q == STEP_W'(MV_W - 1)) begin
					state_d = ST_POW;
				end
			end
			ST_POW: begin
				if (exp_sat) begin
					state_d = ST_SUM;
				end else if (step_q == STEP_W'(STEP_N - 1)) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: state_d = ST_SUM;
			ST_SUM: begin
				ring_we = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (step_q == STEP_W'(TOT_W - 1)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!m_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control counters and ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			slot_q  <= '0;
			full_q  <= 1'b0;
			total_q <= '0;
		end else begin
			if (state_q != state_d) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
			if (ring_we) begin
				total_q <= total_nxt;
				slot_q  <= slot_last ? '0 : slot_inc[SLOT_W-1:0];
				full_q  <= full_q | slot_last;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					d_q    <= MV_W'(zero_ext - mv_ext);
					prod_q <= '0;
					acc_q  <= Q28_ONE;
					inst_q <= PPM_MIN;
				end
			end
			ST_MUL: begin
				prod_q <= {prod_q[PROD_W-2:0], 1'b0} +
					(d_q[MV_W-1] ? PROD_W'(slope_q) : '0);
				d_q    <= {d_q[MV_W-2:0], 1'b0};
			end
			ST_POW: begin
				if (exp_sat) begin
					inst_q <= PPM_MAX;
				end else if (exp_v[step_q[3:0]]) begin
					acc_q <= pw_prod[59:28];
				end
			end
			ST_SCALE: inst_q <= ppm_clamp;
			ST_SUM: begin
				quo_q <= total_nxt;
				rem_q <= '0;
				div_q <= full_q ? CNT_W'(WINDOW) : slot_inc;
			end
			ST_DIV: begin
				quo_q <= {quo_q[TOT_W-2:0], rem_ge};
				rem_q <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[slot_q] <= inst_q;
		end
		rd_q <= ring_mem[slot_q];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_inst_q <= inst_q;
			m_avg_q  <= quo_q[PPM_W-1:0];
			m_full_q <= full_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = MDATA_W'({m_full_q, m_avg_q, m_inst_q});

endmodule

// File: bench/log_sensor_ppm_with_moving_average_test.sv
// Testbench for log_sensor_ppm_with_moving_average: sends sensor readings over the stream input
// and checks every ppm result against a built-in predictor of the log curve and moving average.
// Depends on lsppm_pkg and the DUT only; random stalls on both stream sides.
module log_sensor_ppm_with_moving_average_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lsppm_pkg::*;

	localparam int WINDOW         = 16;
	localparam int SAMPLE_BITS    = 12;
	localparam int IN_W           = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int EXP_OFFSET     = 2664;
	localparam int EXP_CEIL       = 4096;
	localparam int PPM_FLOOR      = 400;
	localparam int PPM_CEIL       = 10000;

	// 10^(2^k/1024) in Q.28
	localparam logic [63:0] POW_STEP [10] = '{
		64'd269039744, 64'd269645392, 64'd270860782, 64'd273308022, 64'd278269033,
		64'd288462842, 64'd309984429, 64'd357964434, 64'd477353244, 64'd848867446
	};

	typedef struct packed {
		logic [PPM_W-1:0] instant;
		logic [PPM_W-1:0] average;
		logic             full;
	} reading_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata;   // sample_mv
	logic                 m_tvalid;
	logic                 m_tready;
	logic [MDATA_W-1:0]   m_tdata;   // instant_ppm, average_ppm, window_full
	logic                 cfg_we;
	logic                 cfg_index;
	logic [SLOPE_W-1:0]   cfg_data;

	// predictor state
	logic [MV_W-1:0]      zero_mv;
	logic [SLOPE_W-1:0]   slope;
	int                   ring [WINDOW];
	int                   slot;
	int                   ring_total;
	bit                   warming;

	reading_t             readings_due [$];
	int                   mismatches;
	int                   burst_left;
	int                   rx_left;
	int                   idle_cycles;

	log_sensor_ppm_with_moving_average #(
		.WINDOW(WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int mv_to_ppm(logic [MV_W-1:0] mv);
		int unsigned drop;
		int unsigned expo;
		logic [63:0] acc;
		int          ppm;
		if (mv >= zero_mv)
			return PPM_FLOOR;
		drop = zero_mv - mv;
		expo = EXP_OFFSET + ((32'(slope) * drop) >> 6);
		if (expo >= EXP_CEIL)
			return PPM_CEIL;
		acc = 64'd1 << 28;
		for (int k = 0; k < 10; k++)
			if (expo[k])
				acc = (acc * POW_STEP[k]) >> 28;
		acc = acc * ((expo >> 10) >= 3 ? 64'd1000 : 64'd100);
		ppm = int'(acc >> 28);
		if (ppm < PPM_FLOOR)
			ppm = PPM_FLOOR;
		if (ppm > PPM_CEIL)
			ppm = PPM_CEIL;
		return ppm;
	endfunction

	function automatic reading_t predict_reading(logic [MV_W-1:0] mv);
		reading_t r;
		int       inst;
		int       divisor;
		inst = mv_to_ppm(mv);
		if (!warming)
			ring_total -= ring[slot];
		ring_total += inst;
		ring[slot] = inst;
		if (warming) begin
			divisor = slot + 1;
			if (slot == WINDOW - 1)
				warming = 1'b0;
		end else begin
			divisor = WINDOW;
		end
		r.instant = PPM_W'(inst);
		r.average = PPM_W'(ring_total / divisor);
		r.full = !warming;
		slot = (slot == WINDOW - 1) ? 0 : slot + 1;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic send_sample(logic [MV_W-1:0] mv);
		s_tdata <= IN_W'(mv);
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		readings_due.push_back(predict_reading(mv));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 70) : $urandom_range(1, 8))
				@(posedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40) : $urandom_range(0, 6);
		end
	endtask

	// sender stops and everything in flight drains
	task automatic settle_idle();
		s_tvalid <= 1'b0;
		wait (readings_due.size() == 0);
		@(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [SLOPE_W-1:0] value);
		settle_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ZERO_POINT: zero_mv = value[MV_W-1:0];
			REG_SLOPE:      slope = value;
		endcase
	endtask

	function automatic logic [MV_W-1:0] pick_sample();
		int span;
		int drop;
		span = (slope == 0) ? 4095 : (1600 * 64) / slope + 1;
		if (span > 4095)
			span = 4095;
		case ($urandom_range(0, 5))
			0: return MV_W'($urandom_range(0, 4095));
			1: return (zero_mv == 0) ? MV_W'(0) : MV_W'(zero_mv - 1);
			2: return MV_W'(zero_mv + $urandom_range(0, 2));
			default: begin
				drop = $urandom_range(1, span);
				if (drop > zero_mv)
					return MV_W'($urandom_range(0, 4095));
				return MV_W'(zero_mv - drop);
			end
		endcase
	endfunction

	// registers still at reset: zero point 0 puts every reading at the baseline
	task automatic test_reset_defaults();
		send_sample(12'd0);
		send_sample(12'd4095);
		send_sample(12'd2048);
	endtask

	task automatic test_curve_edges();
		write_reg(REG_ZERO_POINT, 16'hFFFF);
		write_reg(REG_SLOPE, 16'd64);
		send_sample(12'd4095);   // at zero point
		send_sample(12'd4094);
		send_sample(12'd2664);   // exponent just under saturation
		send_sample(12'd2663);   // exponent hits saturation
		send_sample(12'd0);
		send_sample(12'd3688);   // decade boundary
		send_sample(12'd3687);
		write_reg(REG_SLOPE, 16'd0);
		send_sample(12'd0);      // truncates below 400, raised
		send_sample(12'd1);
		write_reg(REG_SLOPE, 16'hFFFF);
		send_sample(12'd4094);
		send_sample(12'd0);
		write_reg(REG_ZERO_POINT, 16'd2000);
		write_reg(REG_SLOPE, 16'd102);
		send_sample(12'd2000);
		send_sample(12'd2001);
		send_sample(12'd4095);
		send_sample(12'd1999);
		send_sample(12'd0);
		send_sample(12'd1500);
		send_sample(12'd1000);
	endtask

	task automatic test_drain_pause();
		repeat (30) send_sample(pick_sample());
		settle_idle();
		repeat (30) send_sample(pick_sample());
	endtask

	task automatic test_random_stream();
		logic [SLOPE_W-1:0] zp;
		logic [SLOPE_W-1:0] sl;
		int                 count;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					zp = 16'hFFFF;
					sl = 16'hFFFF;
				end
				1: begin
					zp = 16'd0;
					sl = 16'd0;
				end
				2: begin
					zp = 16'd3000;
					sl = 16'd102;
				end
				default: begin
					zp = SLOPE_W'($urandom_range(0, 65535));
					sl = $urandom_range(0, 1) ? SLOPE_W'($urandom_range(1, 400))
						: SLOPE_W'($urandom_range(0, 65535));
				end
			endcase
			write_reg(REG_ZERO_POINT, zp);
			write_reg(REG_SLOPE, sl);
			count = (ph == 1) ? 100 : 340;
			repeat (count) send_sample(pick_sample());
		end
	endtask

	// receiver: alternating runs of ready and stall
	always @(posedge clk) begin
		if (rx_left > 0) begin
			rx_left--;
		end else if ($urandom_range(0, 2) == 0) begin
			m_tready <= 1'b1;
			rx_left = $urandom_range(30, 120);
		end else begin
			m_tready <= $urandom_range(0, 1);
			rx_left = $urandom_range(0, 20);
		end
	end

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (readings_due.size() == 0) begin
				report_mismatch("unexpected transfer, instant_ppm", int'(m_tdata[PPM_W-1:0]), 0);
			end else begin
				want = readings_due.pop_front();
				if (m_tdata[PPM_W-1:0] !== want.instant)
					report_mismatch("instant_ppm", int'(m_tdata[PPM_W-1:0]), int'(want.instant));
				if (m_tdata[2*PPM_W-1:PPM_W] !== want.average)
					report_mismatch("average_ppm", int'(m_tdata[2*PPM_W-1:PPM_W]),
						int'(want.average));
				if (m_tdata[2*PPM_W] !== want.full)
					report_mismatch("window_full", int'(m_tdata[2*PPM_W]), int'(want.full));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end else begin
				idle_cycles++;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ZERO_POINT;
		cfg_data = '0;
		zero_mv = '0;
		slope = SLOPE_RST;
		slot = 0;
		ring_total = 0;
		warming = 1'b1;
		mismatches = 0;
		burst_left = 0;
		rx_left = 0;
		idle_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_curve_edges();
		test_drain_pause();
		test_random_stream();

		settle_idle();
		repeat (60) @(posedge clk);
		if (mismatches == 0 && readings_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
